// ----- rtl/thfc_pkg.sv -----
// Shared types and constants for the tap/hold footswitch controller.
package thfc_pkg;

  // Counter and register width for tick counts.
  localparam int unsigned CNT_W = 10;

  // Number of footswitch lanes (chorus is lane 0, reverb is lane 1).
  localparam int unsigned NUM_LANES = 2;

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 4;

  // Largest value the press counter may hold before it saturates.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] HOLD_TICKS_RESET    = CNT_W'(400);
  localparam logic [CNT_W-1:0] LOCKOUT_TICKS_RESET = CNT_W'(200);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = CFG_IDX_W'(1);

  // One input beat: the level of both footswitches for this tick.
  typedef struct packed {
    logic chorus_switch_pressed;
    logic reverb_switch_pressed;
  } in_item_t;

  // One output beat: effect flags after this tick.
  typedef struct packed {
    logic chorus_enabled;
    logic chorus_frozen;
    logic reverb_enabled;
    logic reverb_frozen;
  } out_item_t;

  // Flags one lane reports to the merge stage.
  typedef struct packed {
    logic enabled;
    logic frozen;
  } lane_result_t;

endpackage

// ----- rtl/thfc_lane.sv -----
// One footswitch lane: edge detection, hold timer, lockout and effect flags.
module thfc_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         level,
  input  logic [thfc_pkg::CNT_W-1:0]   hold_ticks,
  input  logic [thfc_pkg::CNT_W-1:0]   lockout_ticks,
  output thfc_pkg::lane_result_t       result
);

  logic                       level_before;
  logic                       level_before_next;
  logic                       hold_reached;
  logic                       hold_reached_next;
  logic [thfc_pkg::CNT_W-1:0] press_count;
  logic [thfc_pkg::CNT_W-1:0] press_count_next;
  logic [thfc_pkg::CNT_W-1:0] lockout_count;
  logic [thfc_pkg::CNT_W-1:0] lockout_count_next;
  logic                       effect_enabled;
  logic                       effect_enabled_next;
  logic                       effect_frozen;
  logic                       effect_frozen_next;

  logic                       rise;
  logic                       fall;
  logic                       held_now;
  logic [thfc_pkg::CNT_W-1:0] count_now;
  logic [thfc_pkg::CNT_W-1:0] count_inc;

  // Edge detection against the level seen at the last unlocked tick.
  assign rise      = level & ~level_before;
  assign fall      = ~level & level_before;
  assign held_now  = rise ? 1'b0 : hold_reached;
  assign count_now = rise ? '0 : press_count;
  assign count_inc = (count_now == thfc_pkg::CNT_MAX) ? count_now
                                                      : count_now + 1'b1;

  // Per-tick update of the lane state.
  always_comb begin
    level_before_next   = level_before;
    hold_reached_next   = hold_reached;
    press_count_next    = press_count;
    lockout_count_next  = lockout_count;
    effect_enabled_next = effect_enabled;
    effect_frozen_next  = effect_frozen;
    if (lockout_count != '0) begin
      // Locked out: only the lockout counts down.
      lockout_count_next = lockout_count - 1'b1;
    end else begin
      level_before_next = level;
      hold_reached_next = held_now;
      press_count_next  = count_now;
      if (level && !held_now) begin
        press_count_next = count_inc;
        if (count_inc >= hold_ticks) begin
          hold_reached_next = 1'b1;
          if (effect_enabled) begin
            effect_frozen_next = ~effect_frozen;
            lockout_count_next = lockout_ticks;
          end
        end
      end
      if (fall && !held_now) begin
        // A tap toggles the effect; turning it off also clears freeze.
        effect_enabled_next = ~effect_enabled;
        if (effect_enabled) begin
          effect_frozen_next = 1'b0;
        end
        lockout_count_next = lockout_ticks;
      end
    end
  end

  // State registers advance only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_before   <= 1'b0;
      hold_reached   <= 1'b0;
      press_count    <= '0;
      lockout_count  <= '0;
      effect_enabled <= 1'b0;
      effect_frozen  <= 1'b0;
    end else if (step) begin
      level_before   <= level_before_next;
      hold_reached   <= hold_reached_next;
      press_count    <= press_count_next;
      lockout_count  <= lockout_count_next;
      effect_enabled <= effect_enabled_next;
      effect_frozen  <= effect_frozen_next;
    end
  end

  // The result reflects the state after this tick.
  assign result.enabled = effect_enabled_next;
  assign result.frozen  = effect_frozen_next;

endmodule

// ----- rtl/thfc_merge.sv -----
// Merge stage: combines lane results into one beat and buffers it with a skid stage.
module thfc_merge (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             push,
  input  thfc_pkg::lane_result_t [thfc_pkg::NUM_LANES-1:0] lane_results,
  output logic                                             full,
  output logic                                             out_valid,
  input  logic                                             out_stall,
  output thfc_pkg::out_item_t                              out_data
);

  thfc_pkg::out_item_t merged;
  thfc_pkg::out_item_t skid_data;
  logic                skid_full;
  logic                pop;

  // Lane 0 drives the chorus flags, lane 1 the reverb flags.
  assign merged.chorus_enabled = lane_results[0].enabled;
  assign merged.chorus_frozen  = lane_results[0].frozen;
  assign merged.reverb_enabled = lane_results[1].enabled;
  assign merged.reverb_frozen  = lane_results[1].frozen;

  assign pop  = out_valid & ~out_stall;
  assign full = skid_full;

  // Control of the output register and the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (pop) begin
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_full <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= merged;
      end else begin
        out_data <= merged;
      end
    end
  end

endmodule

// ----- rtl/tap_hold_footswitch_controller_core.sv -----
// Top level of the tap/hold footswitch controller for two effects.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data): one beat per control tick,
//   carrying the pressed level of the chorus and reverb footswitches.
//   Output channel (out_valid, out_stall, out_data): one beat per input beat,
//   carrying the on and freeze flags of both effects after that tick.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data):
//   index 0 writes the hold threshold, index 1 the lockout length; other
//   indexes are ignored. cfg_ready is always high.
// Throughput:
//   Results are registered in the output register or the skid entry. One beat
//   is accepted every cycle while in_stall is low; both lanes update per beat.
// Stalls:
//   A two-entry output buffer (register plus skid entry) keeps taking beats
//   while one result waits; in_stall rises only when both entries are full.
// Reset:
//   rst clears all switch state, turns both effects off and unfrozen,
//   empties the output buffer and restores thresholds 400 and 200.
module tap_hold_footswitch_controller_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  thfc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output thfc_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [thfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [thfc_pkg::CNT_W-1:0]        cfg_data
);

  logic [thfc_pkg::CNT_W-1:0]                       hold_ticks;
  logic [thfc_pkg::CNT_W-1:0]                       lockout_ticks;
  logic                                             accept;
  logic                                             buf_full;
  logic [thfc_pkg::NUM_LANES-1:0]                   lane_level;
  thfc_pkg::lane_result_t [thfc_pkg::NUM_LANES-1:0] lane_results;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid & ~buf_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks    <= thfc_pkg::HOLD_TICKS_RESET;
      lockout_ticks <= thfc_pkg::LOCKOUT_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == thfc_pkg::REG_HOLD_TICKS) begin
        hold_ticks <= cfg_data;
      end
      if (cfg_index == thfc_pkg::REG_LOCKOUT_TICKS) begin
        lockout_ticks <= cfg_data;
      end
    end
  end

  // Split the input beat into one level per lane.
  assign lane_level[0] = in_data.chorus_switch_pressed;
  assign lane_level[1] = in_data.reverb_switch_pressed;

  // Identical lanes, one per footswitch.
  for (genvar i = 0; i < thfc_pkg::NUM_LANES; i++) begin : g_lane
    thfc_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .step          (accept),
      .level         (lane_level[i]),
      .hold_ticks    (hold_ticks),
      .lockout_ticks (lockout_ticks),
      .result        (lane_results[i])
    );
  end

  // Merge the lane flags and hand them to the output channel.
  thfc_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .lane_results (lane_results),
    .full         (buf_full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
